>>> src/malc_pkg.sv
// Shared widths, register indexes, level codes and controller states of the level classifier.
package malc_pkg;

  localparam int IN_W       = 10;
  localparam int AVG_W      = 10;
  localparam int WIN_W      = 4;
  localparam int LIM_W      = 10;
  localparam int LEVEL_W    = 3;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  // The divisor is twice the window size; the partial remainder needs one bit more.
  localparam int DIVR_W     = WIN_W + 1;
  localparam int REM_W      = DIVR_W + 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [DIGIT_W-1:0]   digit_t;
  typedef logic [LIM_W-1:0]     limit_t;

  localparam cfg_idx_t REG_WINDOW_SIZE = 3'd0;
  localparam cfg_idx_t REG_EMPTY_LIMIT = 3'd1;
  localparam cfg_idx_t REG_LOW_LIMIT   = 3'd2;
  localparam cfg_idx_t REG_MID_LIMIT   = 3'd3;
  localparam cfg_idx_t REG_HIGH_LIMIT  = 3'd4;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd0;
  localparam limit_t EMPTY_RESET = 10'd10;
  localparam limit_t LOW_RESET   = 10'd200;
  localparam limit_t MID_RESET   = 10'd325;
  localparam limit_t HIGH_RESET  = 10'd400;

  localparam level_t LEVEL_EMPTY = 3'd0;
  localparam level_t LEVEL_LOW   = 3'd1;
  localparam level_t LEVEL_MID   = 3'd2;
  localparam level_t LEVEL_HIGH  = 3'd3;
  localparam level_t LEVEL_FULL  = 3'd4;

  localparam digit_t DIGIT_MAX   = 4'd9;
  localparam digit_t DABBLE_TRIG = 4'd5;
  localparam digit_t DABBLE_ADD  = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_BCD,
    ST_HOLD
  } state_t;

  // Controls from the sequencer to the sample window.
  typedef struct packed {
    logic push;
    logic start;
  } win_ctl_t;

  // Status from the sample window to the sequencer.
  typedef struct packed {
    logic ok;
    logic busy;
  } win_sts_t;

endpackage

>>> src/moving_average_level_classifier_top.sv
// Top level of the moving-average level classifier: registers, sequencer and result register.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_sensor_sample
//   out      output     out_valid / out_stall out_level, out_average, out_*_digit
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A request that gives a result passes through idle, check, the sum (one entry at a time), the
// division (one bit of the dividend at a time, 15 bits by default), the decimal conversion and
// hold, from which the result is loaded into the output register. A request that gives no
// result goes from check straight back to idle.
// Reset is synchronous and clears the sample count, registers and control state.
// A finished result waits in the output register while the next request is taken;
// the sequencer holds only if a second result is ready before the first is taken.
module moving_average_level_classifier_top #(
  parameter int HISTORY_DEPTH = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [malc_pkg::IN_W-1:0]       in_sensor_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output malc_pkg::level_t                out_level,
  output logic [malc_pkg::AVG_W-1:0]      out_average,
  output malc_pkg::digit_t                out_hundreds_digit,
  output malc_pkg::digit_t                out_tens_digit,
  output malc_pkg::digit_t                out_ones_digit,
  input  logic                            cfg_we,
  input  malc_pkg::cfg_idx_t              cfg_index,
  input  logic [malc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import malc_pkg::*;

  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = IN_W + CW;
  localparam int DW    = SUM_W + 1;

  logic [WIN_W-1:0] window_size_r;
  limit_t           empty_limit_r;
  limit_t           low_limit_r;
  limit_t           mid_limit_r;
  limit_t           high_limit_r;

  state_t state_r, state_nxt;

  win_ctl_t         win_ctl;
  win_sts_t         win_sts;
  logic [SUM_W-1:0] win_sum;
  logic             div_start;
  logic             div_busy;
  logic [DW-1:0]    div_quo;
  logic [DW-1:0]    dividend;
  logic             bcd_start;
  logic             bcd_busy;
  digit_t           bcd_hund;
  digit_t           bcd_tens;
  digit_t           bcd_ones;
  logic             accept;
  logic             load_out;
  logic [AVG_W-1:0] avg;
  level_t           level;

  logic             out_valid_r, out_valid_nxt;
  level_t           out_level_r;
  logic [AVG_W-1:0] out_average_r;
  digit_t           out_hund_r;
  digit_t           out_tens_r;
  digit_t           out_ones_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RESET;
      empty_limit_r <= EMPTY_RESET;
      low_limit_r   <= LOW_RESET;
      mid_limit_r   <= MID_RESET;
      high_limit_r  <= HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE: window_size_r <= cfg_wdata[WIN_W-1:0];
        REG_EMPTY_LIMIT: empty_limit_r <= cfg_wdata[LIM_W-1:0];
        REG_LOW_LIMIT:   low_limit_r   <= cfg_wdata[LIM_W-1:0];
        REG_MID_LIMIT:   mid_limit_r   <= cfg_wdata[LIM_W-1:0];
        REG_HIGH_LIMIT:  high_limit_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  malc_window #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (IN_W)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (win_ctl),
    .sample      (in_sensor_sample),
    .window_size (window_size_r),
    .sts         (win_sts),
    .sum         (win_sum)
  );

  // Round half up: (2 * sum + n) / (2 * n).
  assign dividend = {win_sum, 1'b0} + DW'(window_size_r);

  malc_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  ({window_size_r, 1'b0}),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign avg = div_quo[AVG_W-1:0];

  malc_bcd u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (bcd_start),
    .bin      (avg),
    .busy     (bcd_busy),
    .hundreds (bcd_hund),
    .tens     (bcd_tens),
    .ones     (bcd_ones)
  );

  always_comb begin
    if (avg <= empty_limit_r) begin
      level = LEVEL_EMPTY;
    end else if (avg <= low_limit_r) begin
      level = LEVEL_LOW;
    end else if (avg <= mid_limit_r) begin
      level = LEVEL_MID;
    end else if (avg <= high_limit_r) begin
      level = LEVEL_HIGH;
    end else begin
      level = LEVEL_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = win_sts.ok ? ST_SUM : ST_IDLE;
      ST_SUM:   if (!win_sts.busy) state_nxt = ST_DIV;
      ST_DIV:   if (!div_busy) state_nxt = ST_BCD;
      ST_BCD:   if (!bcd_busy) state_nxt = ST_HOLD;
      ST_HOLD:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    accept        = in_valid && (state_r == ST_IDLE);
    win_ctl.push  = accept;
    win_ctl.start = (state_r == ST_CHECK) && win_sts.ok;
    div_start     = (state_r == ST_SUM) && !win_sts.busy;
    bcd_start     = (state_r == ST_DIV) && !div_busy;
    load_out      = (state_r == ST_HOLD) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level_r   <= level;
      out_average_r <= avg;
      out_hund_r    <= bcd_hund;
      out_tens_r    <= bcd_tens;
      out_ones_r    <= bcd_ones;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_level          = out_level_r;
  assign out_average        = out_average_r;
  assign out_hundreds_digit = out_hund_r;
  assign out_tens_digit     = out_tens_r;
  assign out_ones_digit     = out_ones_r;

  a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CHECK))
    else $error("accepted request did not reach the window check");

  a_hold_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_HOLD) && out_valid_r && out_stall) |=> (state_r == ST_HOLD))
    else $error("pending result was overwritten while the output was stalled");

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_hund_r <= DIGIT_MAX) && (out_tens_r <= DIGIT_MAX) &&
                     (out_ones_r <= DIGIT_MAX) && (out_level_r <= LEVEL_FULL)))
    else $error("result digit or level out of range");

endmodule

>>> src/malc_window.sv
// Sample history shift line, saturating sample count and entry-serial window accumulator.
module malc_window #(
  parameter int HISTORY_DEPTH = 9,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  malc_pkg::win_ctl_t                      ctl,
  input  logic [SAMPLE_BITS-1:0]                  sample,
  input  logic [malc_pkg::WIN_W-1:0]              window_size,
  output malc_pkg::win_sts_t                      sts,
  output logic [SAMPLE_BITS+$clog2(HISTORY_DEPTH+1)-1:0] sum
);
  import malc_pkg::*;

  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int IW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W = SAMPLE_BITS + CW;
  localparam int CMP_W = ((CW > WIN_W) ? CW : WIN_W) + 1;

  logic [SAMPLE_BITS-1:0] hist_r [HISTORY_DEPTH];
  logic [CW-1:0]          seen_r;
  logic [CW-1:0]          cnt_r;
  logic [SUM_W-1:0]       acc_r;
  logic                   busy_r;
  logic                   last_add;

  // Entries below the sample count are always written before they are summed,
  // so the history itself needs no reset.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      hist_r[0] <= sample;
      for (int k = 1; k < HISTORY_DEPTH; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (ctl.push && (seen_r != CW'(HISTORY_DEPTH))) begin
      seen_r <= seen_r + CW'(1);
    end
  end

  assign last_add = (CMP_W'(cnt_r) + CMP_W'(1)) == CMP_W'(window_size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (last_add) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + SUM_W'(hist_r[cnt_r[IW-1:0]]);
    end
  end

  assign sts.ok = (window_size != '0) &&
                  (CMP_W'(window_size) <= CMP_W'(HISTORY_DEPTH)) &&
                  (CMP_W'(seen_r) >= CMP_W'(window_size));
  assign sts.busy = busy_r;
  assign sum      = acc_r;

endmodule

>>> src/malc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module malc_div #(
  parameter int DW = 15
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               dividend,
  input  logic [malc_pkg::DIVR_W-1:0] divisor,
  output logic                        busy,
  output logic [DW-1:0]               quotient
);
  import malc_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]     quo_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIVR_W-1:0] divr_r;
  logic [CNT_W-1:0]  step_r;
  logic              busy_r;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;

  // The dividend shifts out of the top of quo_r while quotient bits shift in below.
  assign rem_sh = {rem_r[REM_W-2:0], quo_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, divr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + CNT_W'(1);
      if (step_r == CNT_W'(DW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      divr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? (rem_sh - {1'b0, divr_r}) : rem_sh;
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

  // A remainder at or above the divisor means a quotient bit was lost.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < {1'b0, divr_r}))
    else $error("divider remainder reached the divisor");

endmodule

>>> src/malc_bcd.sv
// Bit-serial double-dabble conversion of the average into three decimal digits.
module malc_bcd (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [malc_pkg::AVG_W-1:0] bin,
  output logic                       busy,
  output malc_pkg::digit_t           hundreds,
  output malc_pkg::digit_t           tens,
  output malc_pkg::digit_t           ones
);
  import malc_pkg::*;

  localparam int BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int CNT_W = $clog2(AVG_W + 1);

  logic [AVG_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] step_r;
  logic             busy_r;

  always_comb begin
    digit_t dig;
    dig = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      dig = bcd_r[d*DIGIT_W +: DIGIT_W];
      adj[d*DIGIT_W +: DIGIT_W] = (dig >= DABBLE_TRIG) ? (dig + DABBLE_ADD) : dig;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + CNT_W'(1);
      if (step_r == CNT_W'(AVG_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The carry out of the hundreds digit is dropped, so values of a thousand
  // and more leave a hundreds digit of zero.
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bcd_r <= {adj[BCD_W-2:0], bin_r[AVG_W-1]};
      bin_r <= {bin_r[AVG_W-2:0], 1'b0};
    end
  end

  assign busy     = busy_r;
  assign ones     = bcd_r[0 +: DIGIT_W];
  assign tens     = bcd_r[DIGIT_W +: DIGIT_W];
  assign hundreds = bcd_r[2*DIGIT_W +: DIGIT_W];

endmodule
